/* hdl/rfb_pkg.sv */
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types, constants and the CRC-32/BZIP2 byte update for the radio
// frame builder.
// ----------------------------------------------------------------------------
package rfb_pkg;

    // input item kinds, carried in tuser
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_PAYLOAD = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_DEST_ADDRESS   = 3'd0;
    localparam logic [2:0] CFG_RADIO_CHANNEL  = 3'd1;
    localparam logic [2:0] CFG_FORMAT_VERSION = 3'd2;
    localparam logic [2:0] CFG_DEVICE_KIND    = 3'd3;
    localparam logic [2:0] CFG_HEADER_FLAGS   = 3'd4;

    // configuration reset values
    localparam logic [15:0] DEST_ADDRESS_RST   = 16'h0002;
    localparam logic [7:0]  RADIO_CHANNEL_RST  = 8'h17;
    localparam logic [3:0]  FORMAT_VERSION_RST = 4'h1;
    localparam logic [3:0]  DEVICE_KIND_RST    = 4'h1;
    localparam logic [3:0]  HEADER_FLAGS_RST   = 4'h0;

    // crc-32/bzip2
    localparam logic [31:0] CRC_POLY   = 32'h04C11DB7;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_START,
        CMD_PAYLOAD
    } cmd_kind_t;

    // one queued command
    typedef struct packed {
        cmd_kind_t   kind;
        logic        last;      // payload: last byte of frame; start: zero length
        logic [3:0]  mtype;
        logic [31:0] tstamp;
        logic [4:0]  len;
        logic [15:0] seq;
        logic [7:0]  data;
    } cmd_t;

    // configuration snapshot
    typedef struct packed {
        logic [15:0] dest_address;
        logic [7:0]  radio_channel;
        logic [3:0]  format_version;
        logic [3:0]  device_kind;
        logic [3:0]  header_flags;
    } cfg_t;

    // back end byte positions within a frame
    typedef enum logic [3:0] {
        ST_ADDR_HI = 4'd0,
        ST_ADDR_LO = 4'd1,
        ST_CHANNEL = 4'd2,
        ST_HDR0    = 4'd3,
        ST_HDR1    = 4'd4,
        ST_SEQ0    = 4'd5,
        ST_SEQ1    = 4'd6,
        ST_TS0     = 4'd7,
        ST_TS1     = 4'd8,
        ST_TS2     = 4'd9,
        ST_TS3     = 4'd10,
        ST_LEN     = 4'd11,
        ST_CRC0    = 4'd12,
        ST_CRC1    = 4'd13,
        ST_CRC2    = 4'd14,
        ST_CRC3    = 4'd15
    } bk_step_t;

    // queue status toward the front end
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // msb-first crc update by one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++)
        begin
            if (c[31])
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hdl/rfb_front.sv */
// ----------------------------------------------------------------------------
// rfb_front
// Accepts input beats, tracks the open frame and sequence number, and turns
// each useful beat into one command for the back end.
// ----------------------------------------------------------------------------
module rfb_front
    import rfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [3:0]  message_type,
    input  logic [31:0] timestamp_seconds,
    input  logic [4:0]  payload_length,
    input  logic [7:0]  payload_byte,
    input  q_stat_t     q_stat,
    output logic        q_push,
    output cmd_t        q_cmd
);

    localparam logic [4:0] LEN_CAP = (MAX_PAYLOAD > 31) ? 5'd31 : 5'(MAX_PAYLOAD);

    logic        open_reg, open_next;
    logic [4:0]  remain_reg, remain_next;
    logic [15:0] seq_reg, seq_next;
    logic [4:0]  len_sat;
    logic        accept;
    logic        pay_ok;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign len_sat  = (payload_length > LEN_CAP) ? LEN_CAP : payload_length;
    assign pay_ok   = open_reg && (remain_reg != 5'd0);

    // classify the beat and build the command
    always_comb
    begin
        open_next   = open_reg;
        remain_next = remain_reg;
        seq_next    = seq_reg;
        q_push      = 1'b0;

        q_cmd.kind   = (mode == MODE_PAYLOAD) ? CMD_PAYLOAD : CMD_START;
        q_cmd.last   = (mode == MODE_PAYLOAD) ? (remain_reg == 5'd1) : (len_sat == 5'd0);
        q_cmd.mtype  = message_type;
        q_cmd.tstamp = timestamp_seconds;
        q_cmd.len    = len_sat;
        q_cmd.seq    = seq_reg;
        q_cmd.data   = payload_byte;

        if (accept)
        begin
            if (mode == MODE_START)
            begin
                q_push      = 1'b1;
                seq_next    = seq_reg + 16'd1;
                open_next   = (len_sat != 5'd0);
                remain_next = len_sat;
            end
            else if (pay_ok)
            begin
                q_push      = 1'b1;
                remain_next = remain_reg - 5'd1;
                if (remain_reg == 5'd1)
                    open_next = 1'b0;
            end
        end
    end

    // frame tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            remain_reg <= 5'd0;
            seq_reg    <= 16'd0;
        end
        else
        begin
            open_reg   <= open_next;
            remain_reg <= remain_next;
            seq_reg    <= seq_next;
        end
    end

endmodule

/* hdl/rfb_queue.sv */
// ----------------------------------------------------------------------------
// rfb_queue
// Short command queue that decouples the front end from the byte sequencer.
// ----------------------------------------------------------------------------
module rfb_queue
    import rfb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head_cmd,
    output q_stat_t stat
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* hdl/rfb_back.sv */
// ----------------------------------------------------------------------------
// rfb_back
// Byte sequencer: walks each command through its frame bytes, keeps the
// running crc and drives the registered output stream.
// ----------------------------------------------------------------------------
module rfb_back
    import rfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  cmd_t       head_cmd,
    input  logic       head_valid,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_end
);

    bk_step_t    step_reg, step_next;
    logic [31:0] crc_reg, crc_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        end_reg, end_next;

    logic        advance;
    logic        done;
    logic        crc_cover;
    logic        pay_step;
    logic [7:0]  cur_byte;
    logic [31:0] crc_out;

    assign advance  = head_valid && (!valid_reg || out_ready);
    assign pay_step = (head_cmd.kind == CMD_PAYLOAD) && (step_reg == ST_ADDR_HI);
    assign crc_out  = crc_reg ^ CRC_XOROUT;
    assign pop      = advance && done;

    // byte select for the current step
    always_comb
    begin
        cur_byte  = 8'h00;
        crc_cover = 1'b0;
        if (pay_step)
        begin
            cur_byte  = head_cmd.data;
            crc_cover = 1'b1;
        end
        else
        begin
            unique case (step_reg)
                ST_ADDR_HI: cur_byte = cfg.dest_address[15:8];
                ST_ADDR_LO: cur_byte = cfg.dest_address[7:0];
                ST_CHANNEL: cur_byte = cfg.radio_channel;
                ST_HDR0:    begin cur_byte = {head_cmd.mtype, cfg.format_version}; crc_cover = 1'b1; end
                ST_HDR1:    begin cur_byte = {cfg.header_flags, cfg.device_kind};  crc_cover = 1'b1; end
                ST_SEQ0:    begin cur_byte = head_cmd.seq[7:0];      crc_cover = 1'b1; end
                ST_SEQ1:    begin cur_byte = head_cmd.seq[15:8];     crc_cover = 1'b1; end
                ST_TS0:     begin cur_byte = head_cmd.tstamp[7:0];   crc_cover = 1'b1; end
                ST_TS1:     begin cur_byte = head_cmd.tstamp[15:8];  crc_cover = 1'b1; end
                ST_TS2:     begin cur_byte = head_cmd.tstamp[23:16]; crc_cover = 1'b1; end
                ST_TS3:     begin cur_byte = head_cmd.tstamp[31:24]; crc_cover = 1'b1; end
                ST_LEN:     begin cur_byte = {3'b000, head_cmd.len}; crc_cover = 1'b1; end
                ST_CRC0:    cur_byte = crc_out[7:0];
                ST_CRC1:    cur_byte = crc_out[15:8];
                ST_CRC2:    cur_byte = crc_out[23:16];
                ST_CRC3:    cur_byte = crc_out[31:24];
                default:    cur_byte = 8'h00;
            endcase
        end
    end

    // next step and end of command
    always_comb
    begin
        step_next = step_reg;
        done      = 1'b0;
        if (pay_step)
            done = !head_cmd.last;
        else if (step_reg == ST_CRC3)
            done = 1'b1;
        else if (step_reg == ST_LEN)
            done = !head_cmd.last;

        if (advance)
        begin
            if (done)
                step_next = ST_ADDR_HI;
            else if (pay_step)
                step_next = ST_CRC0;
            else
                step_next = bk_step_t'(step_reg + 4'd1);
        end
    end

    // crc and output register
    always_comb
    begin
        crc_next   = crc_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            byte_next  = cur_byte;
            end_next   = !pay_step && (step_reg == ST_CRC3);
            if (crc_cover)
                crc_next = crc32_byte(crc_reg, cur_byte);
            else if (!pay_step && (step_reg == ST_CRC3 || step_reg < ST_HDR0))
                crc_next = CRC_INIT;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_ADDR_HI;
            crc_reg   <= CRC_INIT;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_end   = end_reg;

endmodule

/* hdl/radio_frame_builder_crc32.sv */
// ----------------------------------------------------------------------------
// radio_frame_builder_crc32
// Radio frame builder with little-endian CRC-32/BZIP2 trailer.
// ----------------------------------------------------------------------------
// A start beat (tuser 0) produces the frame prefix (address high, address
// low, channel), then header0, header1, sequence number, timestamp and the
// length byte: 12 output beats, 16 when the length is zero because the crc
// follows at once. Each payload beat (tuser 1) of an open frame produces one
// output beat, and the last one five (byte plus four crc bytes). The front
// end accepts one input beat per cycle while its four-entry command queue has
// room; the back end emits one byte per cycle while a command is queued and
// the output is not stalled. Payload beats outside an open frame are accepted
// and dropped. Configuration writes are always ready and should be made only
// while the block is idle.
// ----------------------------------------------------------------------------
module radio_frame_builder_crc32
    import rfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // message_type[3:0], timestamp_seconds[35:4],
                                   // payload_length[40:36], payload_byte[48:41], zero fill
    input  logic        s_tuser,   // mode
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // frame_byte[7:0]
    output logic        m_tlast,   // frame_end
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg_reg;
    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    cmd_t    q_cmd;
    cmd_t    head_cmd;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_address   <= DEST_ADDRESS_RST;
            cfg_reg.radio_channel  <= RADIO_CHANNEL_RST;
            cfg_reg.format_version <= FORMAT_VERSION_RST;
            cfg_reg.device_kind    <= DEVICE_KIND_RST;
            cfg_reg.header_flags   <= HEADER_FLAGS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEST_ADDRESS:   cfg_reg.dest_address   <= cfg_data;
                CFG_RADIO_CHANNEL:  cfg_reg.radio_channel  <= cfg_data[7:0];
                CFG_FORMAT_VERSION: cfg_reg.format_version <= cfg_data[3:0];
                CFG_DEVICE_KIND:    cfg_reg.device_kind    <= cfg_data[3:0];
                CFG_HEADER_FLAGS:   cfg_reg.header_flags   <= cfg_data[3:0];
                default:            ;
            endcase
        end
    end

    // front end
    rfb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .mode              (s_tuser),
        .message_type      (s_tdata[3:0]),
        .timestamp_seconds (s_tdata[35:4]),
        .payload_length    (s_tdata[40:36]),
        .payload_byte      (s_tdata[48:41]),
        .q_stat            (q_stat),
        .q_push            (q_push),
        .q_cmd             (q_cmd)
    );

    // command queue
    rfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    // byte sequencer
    rfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_cmd   (head_cmd),
        .head_valid (!q_stat.empty),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_end    (m_tlast)
    );

`ifndef SYNTHESIS
    // a command is never pushed into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into full queue");

    // the sequencer only retires a command that is present
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // the output register only loads when the downstream side can take it
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && m_tvalid |-> m_tready)
        else $error("sequencer advanced over a stalled output beat");
`endif

endmodule

/* verif/rfb_frame_checker.sv */
// ----------------------------------------------------------------------------
// rfb_frame_checker
// Watches the input, output and configuration channels of the radio frame
// builder. Every accepted input beat is run through a local model of the
// framing and crc logic, and the output beats it should cause are queued.
// Each accepted output beat is compared with the oldest queued beat.
// ----------------------------------------------------------------------------
module rfb_frame_checker
    import rfb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int unsigned errors,
    output int unsigned pending
);

    // one predicted output beat
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    frame_beat_t expected_beats[$];

    // local copy of the block's registers and frame state
    cfg_t        regs;
    logic [15:0] seq_num;
    logic [31:0] crc_acc;
    logic [4:0]  bytes_left;
    logic        in_frame;
    int unsigned mismatch_count = 0;

    // msb-first crc-32 update, one data bit per step
    function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[31] ^ b[i];
            r  = {r[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
        end
        return r;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic last);
        frame_beat_t fb;
        fb.data = b;
        fb.last = last;
        expected_beats.push_back(fb);
    endtask

    // byte that is covered by the crc
    task automatic queue_covered(input logic [7:0] b);
        crc_acc = crc_next(crc_acc, b);
        queue_byte(b, 1'b0);
    endtask

    // crc trailer, little endian, closes the frame
    task automatic queue_trailer();
        logic [31:0] c;
        c = crc_acc ^ CRC_XOROUT;
        queue_byte(c[7:0], 1'b0);
        queue_byte(c[15:8], 1'b0);
        queue_byte(c[23:16], 1'b0);
        queue_byte(c[31:24], 1'b1);
        in_frame   = 1'b0;
        bytes_left = '0;
        crc_acc    = CRC_INIT;
    endtask

    task automatic apply_register(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            CFG_DEST_ADDRESS:   regs.dest_address   = val;
            CFG_RADIO_CHANNEL:  regs.radio_channel  = val[7:0];
            CFG_FORMAT_VERSION: regs.format_version = val[3:0];
            CFG_DEVICE_KIND:    regs.device_kind    = val[3:0];
            CFG_HEADER_FLAGS:   regs.header_flags   = val[3:0];
            default: ;
        endcase
    endtask

    task automatic predict_beat(input logic mode, input logic [55:0] d);
        logic [3:0]  mtype;
        logic [31:0] tstamp;
        logic [4:0]  len;
        logic [7:0]  pbyte;
        mtype  = d[3:0];
        tstamp = d[35:4];
        len    = d[40:36];
        pbyte  = d[48:41];
        if (mode == MODE_START)
        begin
            // oversized lengths saturate
            if (len > MAX_PAYLOAD)
                len = 5'(MAX_PAYLOAD);
            crc_acc = CRC_INIT;
            queue_byte(regs.dest_address[15:8], 1'b0);
            queue_byte(regs.dest_address[7:0], 1'b0);
            queue_byte(regs.radio_channel, 1'b0);
            queue_covered({mtype, regs.format_version});
            queue_covered({regs.header_flags, regs.device_kind});
            queue_covered(seq_num[7:0]);
            queue_covered(seq_num[15:8]);
            seq_num = seq_num + 16'd1;
            queue_covered(tstamp[7:0]);
            queue_covered(tstamp[15:8]);
            queue_covered(tstamp[23:16]);
            queue_covered(tstamp[31:24]);
            queue_covered({3'b000, len});
            in_frame   = 1'b1;
            bytes_left = len;
            if (len == 0)
                queue_trailer();
        end
        else if (in_frame && bytes_left != 0)
        begin
            queue_covered(pbyte);
            bytes_left = bytes_left - 5'd1;
            if (bytes_left == 0)
                queue_trailer();
        end
    endtask

    task automatic check_beat(input logic [7:0] data, input logic last);
        frame_beat_t want;
        if (expected_beats.size() == 0)
        begin
            $error("frame_byte: expected no beat, got %02h (frame_end %0b)", data, last);
            mismatch_count++;
        end
        else
        begin
            want = expected_beats.pop_front();
            if (data !== want.data)
            begin
                $error("frame_byte: expected %02h, got %02h", want.data, data);
                mismatch_count++;
            end
            if (last !== want.last)
            begin
                $error("frame_end: expected %0b, got %0b", want.last, last);
                mismatch_count++;
            end
        end
    endtask

    // follow the handshakes on all three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.dest_address   = DEST_ADDRESS_RST;
            regs.radio_channel  = RADIO_CHANNEL_RST;
            regs.format_version = FORMAT_VERSION_RST;
            regs.device_kind    = DEVICE_KIND_RST;
            regs.header_flags   = HEADER_FLAGS_RST;
            seq_num    = '0;
            crc_acc    = CRC_INIT;
            bytes_left = '0;
            in_frame   = 1'b0;
            expected_beats.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                predict_beat(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_beat(m_tdata, m_tlast);
            errors  <= mismatch_count;
            pending <= expected_beats.size();
        end
    end

endmodule

/* verif/radio_frame_builder_crc32_tb.sv */
// ----------------------------------------------------------------------------
// radio_frame_builder_crc32_tb
// Stimulus and verdict for the radio frame builder.
// A directed run covers empty frames, saturated lengths, stray payload bytes
// and abandoned frames; then random frames run under several register
// settings and with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module radio_frame_builder_crc32_tb;
    import rfb_pkg::*;

    localparam int          PAYLOAD_MAX     = 16;
    localparam int          DRAIN_CYCLES    = 24;
    localparam int          ITEMS_PER_PHASE = 25;
    localparam int          RUN_LIMIT       = 3000000;
    localparam logic [2:0]  CFG_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]  CFG_LAST_UNUSED  = 3'd7;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic        s_tuser   = MODE_START;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_DEST_ADDRESS;
    logic [15:0] cfg_data  = '0;

    int unsigned fail_count;
    int unsigned beats_pending;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    radio_frame_builder_crc32 #(.MAX_PAYLOAD(PAYLOAD_MAX)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rfb_frame_checker #(.MAX_PAYLOAD(PAYLOAD_MAX)) checker_i
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (fail_count),
        .pending   (beats_pending)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // output side back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // run limit
    initial
    begin
        #(RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // one input beat, with an optional idle gap ahead of it
    task automatic send_beat(input logic mode, input logic [3:0] mtype,
                             input logic [31:0] tstamp, input logic [4:0] len,
                             input logic [7:0] pbyte);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'b0, pbyte, len, tstamp, mtype};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // unused fields carry junk, the block must ignore them
    task automatic send_start(input logic [3:0] mtype, input logic [31:0] tstamp,
                              input logic [4:0] len);
        send_beat(MODE_START, mtype, tstamp, len, 8'($urandom_range(255)));
    endtask

    task automatic send_payload(input logic [7:0] b);
        send_beat(MODE_PAYLOAD, 4'($urandom_range(15)), $urandom,
                  5'($urandom_range(31)), b);
    endtask

    // let every predicted beat come out, then let the block settle
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (beats_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all registers back to back, optionally one unmapped index too
    task automatic load_settings(input cfg_t s, input logic add_unused);
        logic [2:0]  idx[6];
        logic [15:0] val[6];
        int          n;
        idx[0] = CFG_DEST_ADDRESS;   val[0] = s.dest_address;
        idx[1] = CFG_RADIO_CHANNEL;  val[1] = {8'($urandom_range(255)), s.radio_channel};
        idx[2] = CFG_FORMAT_VERSION; val[2] = {12'($urandom_range(4095)), s.format_version};
        idx[3] = CFG_DEVICE_KIND;    val[3] = {12'($urandom_range(4095)), s.device_kind};
        idx[4] = CFG_HEADER_FLAGS;   val[4] = {12'($urandom_range(4095)), s.header_flags};
        idx[5] = 3'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED));
        val[5] = 16'($urandom_range(65535));
        n = add_unused ? 6 : 5;
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // random frames: mostly complete, some abandoned, some stray bytes
    task automatic run_frames(input int target);
        int         items;
        logic [4:0] len;
        int         take;
        logic       cut_short;
        items = 0;
        while (items < target)
        begin
            if ($urandom_range(9) == 0)
                len = 5'($urandom_range(31, PAYLOAD_MAX + 1));
            else
                len = 5'($urandom_range(PAYLOAD_MAX));
            send_start(4'($urandom_range(15)), $urandom, len);
            items++;
            take = (len > PAYLOAD_MAX) ? PAYLOAD_MAX : len;
            cut_short = (take > 0 && $urandom_range(9) == 0);
            if (cut_short)
                take = $urandom_range(take - 1);
            for (int i = 0; i < take; i++)
            begin
                send_payload(8'($urandom_range(255)));
                items++;
            end
            if (!cut_short && $urandom_range(9) == 0)
            begin
                send_payload(8'($urandom_range(255)));
                items++;
            end
        end
    endtask

    initial
    begin
        cfg_t settings;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty frames at field extremes
        send_start(4'h0, 32'h0000_0000, 5'd0);
        send_start(4'hF, 32'hFFFF_FFFF, 5'd0);
        // stray byte with no frame open
        send_payload(8'hA5);
        // oversized length saturates to the maximum
        send_start(4'h5, 32'h1234_5678, 5'd31);
        for (int i = 0; i < PAYLOAD_MAX; i++)
            send_payload((i % 2 == 0) ? 8'h00 : 8'hFF);
        // frame abandoned by a new start
        send_start(4'hA, 32'h8000_0001, 5'(PAYLOAD_MAX));
        send_payload(8'h3C);
        send_payload(8'hC3);
        send_start(4'h3, $urandom, 5'd1);
        send_payload(8'hFF);
        wait_for_drain();

        // random phases over register settings and idle patterns
        for (int p = 1; p <= 8; p++)
        begin
            if (p == 1)
                settings = '0;
            else if (p == 2)
                settings = '1;
            else
            begin
                settings.dest_address   = 16'($urandom_range(65535));
                settings.radio_channel  = 8'($urandom_range(255));
                settings.format_version = 4'($urandom_range(15));
                settings.device_kind    = 4'($urandom_range(15));
                settings.header_flags   = 4'($urandom_range(15));
            end
            load_settings(settings, (p % 3 == 0));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            run_frames(ITEMS_PER_PHASE);
            wait_for_drain();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
